>>> sv/adsr_pkg.sv
// Shared constants for the linear ADSR envelope generator.
package adsr_pkg;

   // default widths of time counts and Q1.15-style levels
   localparam int TIME_BITS_DEF  = 24;
   localparam int LEVEL_BITS_DEF = 16;

   // register file addressing
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_IDX_BITS  = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_START_LEVEL     = 3'd0,
      REG_ATTACK_LEVEL    = 3'd1,
      REG_SUSTAIN_LEVEL   = 3'd2,
      REG_RELEASE_LEVEL   = 3'd3,
      REG_ATTACK_SAMPLES  = 3'd4,
      REG_DECAY_SAMPLES   = 3'd5,
      REG_RELEASE_SAMPLES = 3'd6,
      REG_UNUSED          = 3'd7
   } csr_index_type;

endpackage

>>> sv/adsr_front.sv
// Front end: accepts a sample beat and picks the attack, decay or sustain segment.
module adsr_front import adsr_pkg::*; #(
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [TIME_BITS-1:0]         in_held,
   input  logic [TIME_BITS-1:0]         in_released,
   input  logic signed [LEVEL_BITS-1:0] cfg_start,
   input  logic signed [LEVEL_BITS-1:0] cfg_attack,
   input  logic signed [LEVEL_BITS-1:0] cfg_sustain,
   input  logic [TIME_BITS-1:0]         cfg_attack_len,
   input  logic [TIME_BITS-1:0]         cfg_decay_len,
   output logic                         out_valid,
   output logic signed [LEVEL_BITS-1:0] out_a,
   output logic signed [LEVEL_BITS-1:0] out_b,
   output logic [TIME_BITS-1:0]         out_num,
   output logic [TIME_BITS-1:0]         out_den,
   output logic [TIME_BITS-1:0]         out_released
);

   logic                         valid_ff, valid_in;
   logic signed [LEVEL_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [TIME_BITS-1:0]         num_ff, num_in, den_ff, den_in, rel_ff;
   logic [TIME_BITS:0]           ad_end;

   assign valid_in = in_valid;
   assign ad_end   = {1'b0, cfg_attack_len} + {1'b0, cfg_decay_len};

   // classify the segment; sustain is a zero-length step from the sustain level
   always_comb begin
      if (in_held < cfg_attack_len) begin
         a_in   = cfg_start;
         b_in   = cfg_attack;
         num_in = in_held;
         den_in = cfg_attack_len;
      end else if ({1'b0, in_held} < ad_end) begin
         a_in   = cfg_attack;
         b_in   = cfg_sustain;
         num_in = in_held - cfg_attack_len;
         den_in = cfg_decay_len;
      end else begin
         a_in   = cfg_sustain;
         b_in   = cfg_sustain;
         num_in = '0;
         den_in = TIME_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the segment payload
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rel_ff <= in_released;
   end

   assign out_valid    = valid_ff;
   assign out_a        = a_ff;
   assign out_b        = b_ff;
   assign out_num      = num_ff;
   assign out_den      = den_ff;
   assign out_released = rel_ff;

endmodule

>>> sv/adsr_queue.sv
// Two-entry queue between the front end and the interpolation back end.
module adsr_queue import adsr_pkg::*; #(
   parameter int WIDTH = 2 * TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [0:1];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign not_empty = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/adsr_lerp.sv
// Pipelined linear interpolation a + round((b - a) * num / den), one bit of quotient per stage.
module adsr_lerp import adsr_pkg::*; #(
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   parameter int TAG_BITS   = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [LEVEL_BITS-1:0] in_a,
   input  logic signed [LEVEL_BITS-1:0] in_b,
   input  logic [TIME_BITS-1:0]         in_num,
   input  logic [TIME_BITS-1:0]         in_den,
   input  logic [TAG_BITS-1:0]          in_tag,
   output logic                         out_valid,
   output logic signed [LEVEL_BITS-1:0] out_value,
   output logic [TAG_BITS-1:0]          out_tag
);

   localparam int DW = LEVEL_BITS + 1;
   localparam int PW = LEVEL_BITS + TIME_BITS;
   localparam int NW = PW + 2;
   localparam int QB = LEVEL_BITS;

   logic [DW-1:0]         diff, mag_full;
   logic                  neg;

   // product stage
   logic                  p_valid_ff;
   logic [PW-1:0]         p_prod_ff;
   logic [LEVEL_BITS-1:0] p_a_ff;
   logic                  p_neg_ff;
   logic [TIME_BITS-1:0]  p_den_ff;
   logic [TAG_BITS-1:0]   p_tag_ff;

   // divider stages; index 0 is the loaded numerator and divisor
   logic                  d_valid_ff [0:QB];
   logic [NW-1:0]         d_rem_ff   [0:QB];
   logic [TIME_BITS:0]    d_div_ff   [0:QB];
   logic [QB-1:0]         d_quo_ff   [0:QB];
   logic [LEVEL_BITS-1:0] d_a_ff     [0:QB];
   logic                  d_neg_ff   [0:QB];
   logic [TAG_BITS-1:0]   d_tag_ff   [0:QB];

   logic                  o_valid_ff;
   logic [LEVEL_BITS-1:0] o_value_ff;
   logic [TAG_BITS-1:0]   o_tag_ff;

   assign diff     = {in_b[LEVEL_BITS-1], in_b} - {in_a[LEVEL_BITS-1], in_a};
   assign neg      = diff[DW-1];
   assign mag_full = neg ? -diff : diff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) begin
            d_valid_ff[k] <= 1'b0;
         end
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff    <= in_valid;
         d_valid_ff[0] <= p_valid_ff;
         for (int k = 0; k < QB; k++) begin
            d_valid_ff[k+1] <= d_valid_ff[k];
         end
         o_valid_ff <= d_valid_ff[QB];
      end
   end

   // multiply magnitude by the numerator
   always_ff @(posedge clock) begin
      p_prod_ff <= PW'(mag_full[LEVEL_BITS-1:0]) * PW'(in_num);
      p_a_ff    <= in_a;
      p_neg_ff  <= neg;
      p_den_ff  <= in_den;
      p_tag_ff  <= in_tag;
   end

   // load 2*prod + den over 2*den, then restore one quotient bit per stage
   always_ff @(posedge clock) begin
      d_rem_ff[0] <= {p_prod_ff, 1'b0} + NW'(p_den_ff);
      d_div_ff[0] <= {p_den_ff, 1'b0};
      d_quo_ff[0] <= '0;
      d_a_ff[0]   <= p_a_ff;
      d_neg_ff[0] <= p_neg_ff;
      d_tag_ff[0] <= p_tag_ff;
      for (int k = 0; k < QB; k++) begin
         if (d_rem_ff[k] >= (NW'(d_div_ff[k]) << (QB - 1 - k))) begin
            d_rem_ff[k+1] <= d_rem_ff[k] - (NW'(d_div_ff[k]) << (QB - 1 - k));
            d_quo_ff[k+1] <= d_quo_ff[k] | (QB'(1) << (QB - 1 - k));
         end else begin
            d_rem_ff[k+1] <= d_rem_ff[k];
            d_quo_ff[k+1] <= d_quo_ff[k];
         end
         d_div_ff[k+1] <= d_div_ff[k];
         d_a_ff[k+1]   <= d_a_ff[k];
         d_neg_ff[k+1] <= d_neg_ff[k];
         d_tag_ff[k+1] <= d_tag_ff[k];
      end
   end

   // apply the signed step to the start level
   always_ff @(posedge clock) begin
      o_value_ff <= d_neg_ff[QB] ? d_a_ff[QB] - d_quo_ff[QB] : d_a_ff[QB] + d_quo_ff[QB];
      o_tag_ff   <= d_tag_ff[QB];
   end

   assign out_valid = o_valid_ff;
   assign out_value = o_value_ff;
   assign out_tag   = o_tag_ff;

endmodule

>>> sv/adsr_back.sv
// Back end: segment interpolation, then release interpolation toward the release level.
module adsr_back import adsr_pkg::*; #(
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [LEVEL_BITS-1:0] in_a,
   input  logic signed [LEVEL_BITS-1:0] in_b,
   input  logic [TIME_BITS-1:0]         in_num,
   input  logic [TIME_BITS-1:0]         in_den,
   input  logic [TIME_BITS-1:0]         in_released,
   input  logic signed [LEVEL_BITS-1:0] cfg_release,
   input  logic [TIME_BITS-1:0]         cfg_release_len,
   output logic                         out_valid,
   output logic signed [LEVEL_BITS-1:0] out_amplitude
);

   logic                         seg_valid;
   logic signed [LEVEL_BITS-1:0] seg_value;
   logic [TIME_BITS-1:0]         seg_rel;
   logic signed [LEVEL_BITS-1:0] rel_a, rel_b;
   logic [TIME_BITS-1:0]         rel_num, rel_den;
   logic                         unused_tag;

   adsr_lerp #(
      .TIME_BITS (TIME_BITS),
      .LEVEL_BITS(LEVEL_BITS),
      .TAG_BITS  (TIME_BITS)
   ) u_seg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_a     (in_a),
      .in_b     (in_b),
      .in_num   (in_num),
      .in_den   (in_den),
      .in_tag   (in_released),
      .out_valid(seg_valid),
      .out_value(seg_value),
      .out_tag  (seg_rel)
   );

   // pick release behavior: key held, release finished, or moving
   always_comb begin
      if (seg_rel == '0) begin
         rel_a   = seg_value;
         rel_b   = seg_value;
         rel_num = '0;
         rel_den = TIME_BITS'(1);
      end else if (seg_rel >= cfg_release_len) begin
         rel_a   = cfg_release;
         rel_b   = cfg_release;
         rel_num = '0;
         rel_den = TIME_BITS'(1);
      end else begin
         rel_a   = seg_value;
         rel_b   = cfg_release;
         rel_num = seg_rel;
         rel_den = cfg_release_len;
      end
   end

   adsr_lerp #(
      .TIME_BITS (TIME_BITS),
      .LEVEL_BITS(LEVEL_BITS),
      .TAG_BITS  (1)
   ) u_rel (
      .clock    (clock),
      .reset    (reset),
      .in_valid (seg_valid),
      .in_a     (rel_a),
      .in_b     (rel_b),
      .in_num   (rel_num),
      .in_den   (rel_den),
      .in_tag   (1'b0),
      .out_valid(out_valid),
      .out_value(out_amplitude),
      .out_tag  (unused_tag)
   );

endmodule

>>> sv/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator with its register file.
//
//   channel   ports                          handshake
//   request   req_held_time, req_released_time   start high while busy low
//   response  rsp_amplitude                  rsp_valid, one cycle, no back-pressure
//   control   csr_*                          APB-style, pready always high
//
// One sample beat is taken per cycle while busy is low; each request
// passes through one front register, one queue slot and two pipelined
// interpolators of LEVEL_BITS + 3 stages, each resolving one quotient
// bit per divider stage.
// Synchronous reset clears all valid state and loads the register defaults.
// The back end never stalls, so busy only rises if the queue were ever full.
module adsr_envelope_generator import adsr_pkg::*; #(
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [TIME_BITS-1:0]         req_held_time,
   input  logic [TIME_BITS-1:0]         req_released_time,
   output logic                         rsp_valid,
   output logic signed [LEVEL_BITS-1:0] rsp_amplitude,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int QW = 2 * LEVEL_BITS + 3 * TIME_BITS;

   logic signed [LEVEL_BITS-1:0] start_ff, attack_ff, sustain_ff, release_ff;
   logic [TIME_BITS-1:0]         attack_len_ff, decay_len_ff, release_len_ff;
   csr_index_type                csr_idx;
   logic                         csr_write;

   logic                         f_valid;
   logic signed [LEVEL_BITS-1:0] f_a, f_b;
   logic [TIME_BITS-1:0]         f_num, f_den, f_rel;
   logic                         q_not_empty, q_full;
   logic [QW-1:0]                q_out;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign busy       = q_full;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff       <= '0;
         attack_ff      <= {1'b0, {(LEVEL_BITS-1){1'b1}}};
         sustain_ff     <= {1'b0, {(LEVEL_BITS-1){1'b1}}};
         release_ff     <= '0;
         attack_len_ff  <= '0;
         decay_len_ff   <= '0;
         release_len_ff <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_START_LEVEL:     start_ff       <= csr_pwdata[LEVEL_BITS-1:0];
            REG_ATTACK_LEVEL:    attack_ff      <= csr_pwdata[LEVEL_BITS-1:0];
            REG_SUSTAIN_LEVEL:   sustain_ff     <= csr_pwdata[LEVEL_BITS-1:0];
            REG_RELEASE_LEVEL:   release_ff     <= csr_pwdata[LEVEL_BITS-1:0];
            REG_ATTACK_SAMPLES:  attack_len_ff  <= csr_pwdata[TIME_BITS-1:0];
            REG_DECAY_SAMPLES:   decay_len_ff   <= csr_pwdata[TIME_BITS-1:0];
            REG_RELEASE_SAMPLES: release_len_ff <= csr_pwdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_idx)
         REG_START_LEVEL:     csr_prdata = 32'({{(32-LEVEL_BITS){1'b0}}, start_ff});
         REG_ATTACK_LEVEL:    csr_prdata = 32'({{(32-LEVEL_BITS){1'b0}}, attack_ff});
         REG_SUSTAIN_LEVEL:   csr_prdata = 32'({{(32-LEVEL_BITS){1'b0}}, sustain_ff});
         REG_RELEASE_LEVEL:   csr_prdata = 32'({{(32-LEVEL_BITS){1'b0}}, release_ff});
         REG_ATTACK_SAMPLES:  csr_prdata = 32'(attack_len_ff);
         REG_DECAY_SAMPLES:   csr_prdata = 32'(decay_len_ff);
         REG_RELEASE_SAMPLES: csr_prdata = 32'(release_len_ff);
         default:             csr_prdata = '0;
      endcase
   end

   adsr_front #(
      .TIME_BITS (TIME_BITS),
      .LEVEL_BITS(LEVEL_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .in_held       (req_held_time),
      .in_released   (req_released_time),
      .cfg_start     (start_ff),
      .cfg_attack    (attack_ff),
      .cfg_sustain   (sustain_ff),
      .cfg_attack_len(attack_len_ff),
      .cfg_decay_len (decay_len_ff),
      .out_valid     (f_valid),
      .out_a         (f_a),
      .out_b         (f_b),
      .out_num       (f_num),
      .out_den       (f_den),
      .out_released  (f_rel)
   );

   adsr_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_data({f_a, f_b, f_num, f_den, f_rel}),
      .pop      (q_not_empty),
      .not_empty(q_not_empty),
      .full     (q_full),
      .pop_data (q_out)
   );

   adsr_back #(
      .TIME_BITS (TIME_BITS),
      .LEVEL_BITS(LEVEL_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_not_empty),
      .in_a           (q_out[QW-1 -: LEVEL_BITS]),
      .in_b           (q_out[QW-LEVEL_BITS-1 -: LEVEL_BITS]),
      .in_num         (q_out[3*TIME_BITS-1 -: TIME_BITS]),
      .in_den         (q_out[2*TIME_BITS-1 -: TIME_BITS]),
      .in_released    (q_out[TIME_BITS-1:0]),
      .cfg_release    (release_ff),
      .cfg_release_len(release_len_ff),
      .out_valid      (rsp_valid),
      .out_amplitude  (rsp_amplitude)
   );

endmodule
